// ----- rtl/skl_pkg.sv -----
// Shared widths and the command/status bundles between the controller and the datapath.
package skl_pkg;

  // Sample and rank widths.
  localparam int DATA_W = 32;
  localparam int RANK_W = 7;

  // Commands from the controller to the datapath, one step of the heap walk each.
  typedef struct packed {
    logic load;      // take the accepted request and set up the walk
    logic up_read;   // sift-up: fetch the parent, or place the sample at the root
    logic up_cmp;    // sift-up: move the parent down or place the sample
    logic dn_read;   // sift-down: fetch both children, or place the sample at a leaf
    logic dn_cmp;    // sift-down: move the smaller child up or place the sample
    logic out_load;  // load the root into the output register
  } skl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_lt_k;  // heap still filling: the request is an insert
    logic gt_root;    // incoming sample beats the current root
    logic pos_zero;   // hole sits at the root
    logic up_move;    // sample is below its parent
    logic dn_leaf;    // hole has no child inside the heap
    logic dn_move;    // a child is below the sample
    logic emit;       // this request produces a result
    logic out_busy;   // output register still holds an untaken result
  } skl_status_t;

endpackage

// ----- rtl/streaming_kth_largest.sv -----
// Top level of the streaming k-th largest tracker.
// Keeps the k largest signed 32-bit samples of a stream in a binary min-heap held in a
// K_MAX-entry RAM with registered reads, and for every sample from the k-th on returns
// the heap root, the current k-th largest value; earlier samples return nothing. One
// sample is in work at a time. The walk through the heap sets the time per sample: the
// sample is accepted, then each step of the walk reads the parent or both children and
// then compares and writes back, where the step that reaches the root on the way up or
// a node without children on the way down needs only its read, and last the result is
// handed to the output register. A sample not above the root skips the walk. A result
// waiting in the output register does not stop the next sample from being accepted,
// but that sample's walk then holds in its final hand-off state until the register is
// free. Writing rank_k (cfg_data) restarts the stream: held samples are dropped. A rank
// of zero acts as one, a rank above K_MAX acts as K_MAX.
module streaming_kth_largest #(
  parameter int K_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Sample requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] kth_largest
  // Rank register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // [6:0] rank_k
);

  skl_pkg::skl_cmd_t    cmd;
  skl_pkg::skl_status_t status;
  logic signed [skl_pkg::DATA_W-1:0] kth_largest;

  assign cfg_ready = 1'b1;
  assign m_tdata   = kth_largest;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  skl_dp #(
    .K_MAX (K_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (s_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_rank    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .kth_largest (kth_largest)
  );

endmodule

// ----- rtl/skl_ram.sv -----
// Generic simple RAM: one write port, two read ports, registered read data.
module skl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/skl_dp.sv -----
// Datapath: rank and fill registers, hole position, root copy, heap RAM and output register.
module skl_dp #(
  parameter int K_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  skl_pkg::skl_cmd_t                  cmd,
  output skl_pkg::skl_status_t               status,
  input  logic signed [skl_pkg::DATA_W-1:0]  sample,
  input  logic                               cfg_we,
  input  logic [skl_pkg::RANK_W-1:0]         cfg_rank,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [skl_pkg::DATA_W-1:0]  kth_largest
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(K_MAX + 1);
  localparam int XW = (CW > skl_pkg::RANK_W) ? CW : skl_pkg::RANK_W;
  localparam int IW = AW + 2;

  logic [skl_pkg::RANK_W-1:0]        rank_k;
  logic [CW-1:0]                     fill;
  logic [AW-1:0]                     pos;
  logic signed [skl_pkg::DATA_W-1:0] x;
  logic signed [skl_pkg::DATA_W-1:0] root;
  logic                              emit;

  logic [CW-1:0]                     k_eff;
  logic [AW-1:0]                     parent;
  logic [IW-1:0]                     left;
  logic [IW-1:0]                     right;
  logic [IW-1:0]                     count;
  logic                              left_ok;
  logic                              right_ok;
  logic signed [skl_pkg::DATA_W-1:0] rd_a;
  logic signed [skl_pkg::DATA_W-1:0] rd_b;
  logic signed [skl_pkg::DATA_W-1:0] cur;
  logic                              sel_left;
  logic                              sel_right;
  logic                              up_move;
  logic [AW-1:0]                     child;
  logic signed [skl_pkg::DATA_W-1:0] child_val;

  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [skl_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]                     raddr_a;
  logic [AW-1:0]                     raddr_b;
  logic [skl_pkg::DATA_W-1:0]        rdata_a;
  logic [skl_pkg::DATA_W-1:0]        rdata_b;

  // Clamp the rank: zero acts as one, above capacity acts as capacity.
  always_comb begin
    if (rank_k == '0) begin
      k_eff = CW'(1);
    end else if (XW'(rank_k) > XW'(K_MAX)) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(rank_k);
    end
  end

  // Tree neighbors of the hole.
  assign parent   = AW'((pos - AW'(1)) >> 1);
  assign left     = {1'b0, pos, 1'b1};
  assign right    = IW'({1'b0, pos} + (AW + 1)'(1)) << 1;
  assign count    = IW'(fill);
  assign left_ok  = left < count;
  assign right_ok = right < count;

  // Pick the smallest of sample, left child and right child (strict less).
  assign rd_a      = rdata_a;
  assign rd_b      = rdata_b;
  assign up_move   = x < rd_a;
  assign sel_left  = left_ok && (rd_a < x);
  assign cur       = sel_left ? rd_a : x;
  assign sel_right = right_ok && (rd_b < cur);
  assign child     = sel_right ? right[AW-1:0] : left[AW-1:0];
  assign child_val = sel_right ? rd_b : rd_a;

  // Status toward the controller.
  always_comb begin
    status.fill_lt_k = fill < k_eff;
    status.gt_root   = sample > root;
    status.pos_zero  = pos == '0;
    status.up_move   = up_move;
    status.dn_leaf   = !left_ok;
    status.dn_move   = sel_left || sel_right;
    status.emit      = emit;
    status.out_busy  = out_valid && !out_ready;
  end

  // Read addresses: parent on port A for sift-up, both children for sift-down.
  assign raddr_a = cmd.dn_read ? left[AW-1:0] : parent;
  assign raddr_b = right[AW-1:0];

  // Heap write for the current step.
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = x;
    if (cmd.up_read) begin
      we = status.pos_zero;
    end else if (cmd.up_cmp) begin
      we    = 1'b1;
      wdata = up_move ? rd_a : x;
    end else if (cmd.dn_read) begin
      we = !left_ok;
    end else if (cmd.dn_cmp) begin
      we    = 1'b1;
      wdata = (sel_left || sel_right) ? child_val : x;
    end
  end

  skl_ram #(
    .WIDTH (skl_pkg::DATA_W),
    .DEPTH (K_MAX)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Rank and fill count; a rank write restarts the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= skl_pkg::RANK_W'(1);
      fill   <= '0;
    end else if (cfg_we) begin
      rank_k <= cfg_rank;
      fill   <= '0;
    end else if (cmd.load && status.fill_lt_k) begin
      fill <= fill + CW'(1);
    end
  end

  // Latch the request and walk the hole.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= sample;
      emit <= !status.fill_lt_k || ((fill + CW'(1)) == k_eff);
      pos  <= status.fill_lt_k ? fill[AW-1:0] : '0;
    end else if (cmd.up_cmp && up_move) begin
      pos <= parent;
    end else if (cmd.dn_cmp && (sel_left || sel_right)) begin
      pos <= child;
    end
  end

  // Keep a copy of entry zero.
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root <= wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kth_largest <= root;
    end
  end

endmodule

// ----- rtl/skl_ctrl.sv -----
// Controller: sequences the sift-up and sift-down walks and the result hand-off.
module skl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  skl_pkg::skl_status_t status,
  output skl_pkg::skl_cmd_t    cmd
);

  localparam logic [2:0] IDLE   = 3'd0;
  localparam logic [2:0] UP_RD  = 3'd1;
  localparam logic [2:0] UP_CMP = 3'd2;
  localparam logic [2:0] DN_RD  = 3'd3;
  localparam logic [2:0] DN_CMP = 3'd4;
  localparam logic [2:0] FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == IDLE;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.fill_lt_k) begin
            state_next = UP_RD;
          end else if (status.gt_root) begin
            state_next = DN_RD;
          end else begin
            state_next = FIN;
          end
        end
      end
      UP_RD: begin
        cmd.up_read = 1'b1;
        state_next  = status.pos_zero ? FIN : UP_CMP;
      end
      UP_CMP: begin
        cmd.up_cmp = 1'b1;
        state_next = status.up_move ? UP_RD : FIN;
      end
      DN_RD: begin
        cmd.dn_read = 1'b1;
        state_next  = status.dn_leaf ? FIN : DN_CMP;
      end
      DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        state_next = status.dn_move ? DN_RD : FIN;
      end
      FIN: begin
        if (!status.emit) begin
          state_next = IDLE;
        end else if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- bench/kth_largest_checker.sv -----
`timescale 1ns / 1ps
// Stream monitor that tracks the k largest samples and checks every k-th largest result.
module kth_largest_checker #(
  parameter int K_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [skl_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [skl_pkg::DATA_W-1:0]  m_tdata,   // [31:0] kth_largest
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [skl_pkg::RANK_W-1:0]  cfg_data,  // [6:0] rank_k
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);

  typedef logic signed [skl_pkg::DATA_W-1:0] sample_t;

  // Shadow of the block: min-heap of the k largest, its fill level and the rank
  sample_t                     top_k_heap [K_MAX];
  int                          top_k_fill;
  logic [skl_pkg::RANK_W-1:0]  rank_setting;
  sample_t                     kth_expected [$];

  sample_t                     got_root;
  bit                          got_emit;
  sample_t                     want;

  initial begin
    fail_count = 0;
    checked    = 0;
    pending    = 0;
  end

  // Clamp the rank into 1..K_MAX
  function automatic int active_rank();
    int r;
    r = rank_setting;
    if (r == 0) r = 1;
    if (r > K_MAX) r = K_MAX;
    return r;
  endfunction

  // Fold one sample into the heap; report whether it yields a result and the root
  task automatic absorb_sample(input sample_t x, output bit emits, output sample_t root);
    int      k;
    int      pos;
    int      up;
    int      low;
    int      lc;
    int      rc;
    sample_t t;
    k     = active_rank();
    emits = 1'b1;
    if (top_k_fill < k) begin
      // Insert at the end and sift up
      pos = top_k_fill;
      top_k_heap[pos] = x;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (top_k_heap[pos] < top_k_heap[up]) begin
          t = top_k_heap[pos];
          top_k_heap[pos] = top_k_heap[up];
          top_k_heap[up] = t;
          pos = up;
        end else begin
          break;
        end
      end
      top_k_fill++;
      if (top_k_fill < k) emits = 1'b0;
    end else if (x > top_k_heap[0]) begin
      // Replace the root and sift down
      top_k_heap[0] = x;
      pos = 0;
      forever begin
        low = pos;
        lc  = 2 * pos + 1;
        rc  = 2 * pos + 2;
        if (lc < top_k_fill && top_k_heap[lc] < top_k_heap[low]) low = lc;
        if (rc < top_k_fill && top_k_heap[rc] < top_k_heap[low]) low = rc;
        if (low == pos) break;
        t = top_k_heap[pos];
        top_k_heap[pos] = top_k_heap[low];
        top_k_heap[low] = t;
        pos = low;
      end
    end
    root = top_k_heap[0];
  endtask

  // Check results, track rank writes and predict from accepted requests
  always @(posedge clk) begin
    if (rst) begin
      kth_expected.delete();
      top_k_fill   = 0;
      rank_setting = 7'd1;
      pending     <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (kth_expected.size() == 0) begin
          fail_count++;
          $display("%0t: kth_largest expected none, actual %0d", $time, $signed(m_tdata));
        end else begin
          want = kth_expected.pop_front();
          checked++;
          if (m_tdata !== want) begin
            fail_count++;
            $display("%0t: kth_largest expected %0d, actual %0d",
                     $time, want, $signed(m_tdata));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        rank_setting = cfg_data;
        top_k_fill   = 0;
      end
      if (s_tvalid && s_tready) begin
        absorb_sample(s_tdata, got_emit, got_root);
        if (got_emit) kth_expected.insert(kth_expected.size(), got_root);
      end
      pending <= kth_expected.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the k-th largest tracker bench: clock, reset, request stimulus and verdict.
module testbench;

  localparam int LIMIT         = 600000;
  localparam int ITEMS         = 1450;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;

  // Sample styles for a phase
  typedef enum int {
    STY_FULL,
    STY_TIES,
    STY_RISING,
    STY_FALLING,
    STY_EXTREMES
  } style_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [6:0]  cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic        cfg_ready;

  int fail_count;
  int pending;
  int checked;

  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycles       = 0;
  int samples_sent = 0;
  int rank_writes  = 0;
  logic [31:0] ramp_val;

  always #5 clk = ~clk;

  streaming_kth_largest DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kth_largest_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Drive result ready: long hold on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one sample request, with random gaps before it
  task automatic offer_sample(input logic [31:0] x);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Hold off until every due result is back and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the rank register; call only when idle
  task automatic write_rank(input logic [6:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rank_writes++;
  endtask

  // Pick the next sample for a style, with some full-range noise mixed in
  task automatic next_sample(input style_t sty, output logic [31:0] x);
    if ($urandom_range(0, 99) < 15) begin
      x = $urandom;
    end else begin
      case (sty)
        STY_FULL: begin
          x = $urandom;
        end
        STY_TIES: begin
          x = $urandom_range(0, 8) - 4;
        end
        STY_RISING: begin
          ramp_val = ramp_val + $urandom_range(0, 3);
          x = ramp_val;
        end
        STY_FALLING: begin
          ramp_val = ramp_val - $urandom_range(0, 3);
          x = ramp_val;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       x = 32'h7FFF_FFFF;
            1:       x = 32'h8000_0000;
            2:       x = 32'h7FFF_FFFF - $urandom_range(0, 2);
            default: x = 32'h8000_0000 + $urandom_range(0, 2);
          endcase
        end
      endcase
    end
  endtask

  // Stimulus
  initial begin
    logic [6:0]  rank_plan [10];
    logic [6:0]  rank;
    logic [31:0] x;
    int          eff;
    int          n;
    int          p;
    style_t      sty;

    rank_plan = '{7'd2, 7'd64, 7'd7, 7'd127, 7'd0, 7'd33, 7'd1, 7'd65, 7'd16, 7'd4};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default rank of one: extremes of the sample
    offer_sample(32'h7FFF_FFFF);
    offer_sample(32'h8000_0000);
    drain();

    // Rank zero acts as one; ties with the root
    write_rank(7'd0);
    offer_sample(32'h8000_0000);
    offer_sample(32'hFFFF_FFFF);
    offer_sample(32'hFFFF_FFFF);
    offer_sample(32'h0000_0000);
    drain();

    // Rank write while the heap is still filling drops the held samples
    write_rank(7'd5);
    offer_sample(32'd100);
    offer_sample(32'd200);
    drain();
    write_rank(7'd3);
    offer_sample(32'd5);
    offer_sample(-32'sd5);
    offer_sample(32'd5);
    offer_sample(32'd5);
    offer_sample(32'h7FFF_FFFF);
    offer_sample(32'h8000_0000);
    offer_sample(32'd6);
    drain();

    // Rank two with a rising run: once the heap is full, every sample replaces the root
    write_rank(7'd2);
    offer_sample(32'd1);
    offer_sample(32'd2);
    offer_sample(32'd3);
    offer_sample(32'd4);
    drain();

    // Random phases over rank settings and idle patterns
    p = 0;
    while (samples_sent < ITEMS + 19) begin
      rank = (p < 10) ? rank_plan[p] : 7'($urandom_range(0, 127));
      eff  = (rank == 0) ? 1 : ((rank > 64) ? 64 : rank);
      case (p % 4)
        0: begin
          tx_gap_pct   <= 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_gap_pct   <= 51;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_gap_pct   <= 0;
          rx_stall_pct <= 51;
        end
        default: begin
          tx_gap_pct   <= 8;
          rx_stall_pct <= 8;
        end
      endcase
      write_rank(rank);
      sty      = style_t'($urandom_range(0, 4));
      ramp_val = $urandom;
      n        = eff + $urandom_range(30, 90);
      // Long receiver hold while requests keep coming
      if (p == 4) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < n; i++) begin
        // Pause the sender mid-phase until every result is back
        if (p == 5 && i == n / 2) drain();
        next_sample(sty, x);
        offer_sample(x);
      end
      drain();
      p++;
    end

    $display("Ran %0d samples over %0d rank writes (ranks 0..127, heap up to 64 deep),",
             samples_sent, rank_writes);
    $display("checked %0d results under no idling, sender gaps, receiver stalls and a long hold.",
             checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
